### hdl/ppc_pkg.sv
// types, codes and signature table of the payload protocol classifier
package ppc_pkg;

    localparam int HEAD_BITS = 128;
    localparam int LEN_W = 16;
    localparam int MIN_LEN_W = 5;
    localparam int NUM_PATS = 35;
    localparam int IDX_QUIC = 8;
    localparam int IDX_COAP = 9;
    localparam int DNS_AFTER = 9;
    localparam int MIN_PAYLOAD = 2;
    localparam int DNS_MIN_LEN = 12;
    localparam int NTP_MIN_LEN = 8;
    localparam int DNS_COUNT_LIMIT = 64;

    typedef enum logic [3:0] {
        CODE_UNKNOWN = 4'd0,
        CODE_TLS     = 4'd1,
        CODE_SSH     = 4'd2,
        CODE_MQTT    = 4'd3,
        CODE_RTSP    = 4'd4,
        CODE_QUIC    = 4'd5,
        CODE_COAP    = 4'd6,
        CODE_DNS     = 4'd7,
        CODE_HTTP1   = 4'd8,
        CODE_HTTP2   = 4'd9,
        CODE_SIP     = 4'd10,
        CODE_SMTP    = 4'd11,
        CODE_NTP     = 4'd12,
        CODE_FTP     = 4'd13
    } code_t;

    typedef struct packed {
        logic [HEAD_BITS-1:0] value;
        logic [HEAD_BITS-1:0] mask;
        logic [MIN_LEN_W-1:0] min_len;
        logic                 definite;
        code_t                code;
    } pattern_t;

    typedef struct packed {
        logic [NUM_PATS-1:0] hit;
        logic                dns;
        logic                ntp;
        logic                len_ok;
    } lane_hits_t;

    typedef struct packed {
        code_t code;
        logic  by_signature;
    } result_t;

    function automatic logic [HEAD_BITS-1:0] lead_mask(input int unsigned n);
        lead_mask = ~({HEAD_BITS{1'b1}} >> (8 * n));
    endfunction

    // priority order, hint entries carry definite = 0
    localparam pattern_t PATTERNS [NUM_PATS] = '{
        '{{8'h16, 8'h03, 112'h0}, lead_mask(2), 5'd5, 1'b1, CODE_TLS},
        '{{"SSH-", 96'h0}, lead_mask(4), 5'd4, 1'b1, CODE_SSH},
        '{{8'h10, 120'h0}, {8'hF0, 120'h0}, 5'd0, 1'b1, CODE_MQTT},
        '{{"RTSP/", 88'h0}, lead_mask(5), 5'd5, 1'b1, CODE_RTSP},
        '{{"OPTIONS ", 64'h0}, lead_mask(8), 5'd8, 1'b1, CODE_RTSP},
        '{{"DESCRIBE ", 56'h0}, lead_mask(9), 5'd9, 1'b1, CODE_RTSP},
        '{{"SETUP ", 80'h0}, lead_mask(6), 5'd6, 1'b1, CODE_RTSP},
        '{{"PLAY ", 88'h0}, lead_mask(5), 5'd5, 1'b1, CODE_RTSP},
        '{{8'h80, 120'h0}, {8'h80, 120'h0}, 5'd6, 1'b0, CODE_QUIC},
        '{{8'h40, 120'h0}, {8'hC0, 120'h0}, 5'd4, 1'b0, CODE_COAP},
        '{{"GET ", 96'h0}, lead_mask(4), 5'd4, 1'b1, CODE_HTTP1},
        '{{"POST ", 88'h0}, lead_mask(5), 5'd5, 1'b1, CODE_HTTP1},
        '{{"PUT ", 96'h0}, lead_mask(4), 5'd4, 1'b1, CODE_HTTP1},
        '{{"DELETE ", 72'h0}, lead_mask(7), 5'd7, 1'b1, CODE_HTTP1},
        '{{"HEAD ", 88'h0}, lead_mask(5), 5'd5, 1'b1, CODE_HTTP1},
        '{{"OPTIONS ", 64'h0}, lead_mask(8), 5'd8, 1'b1, CODE_HTTP1},
        '{{"PATCH ", 80'h0}, lead_mask(6), 5'd6, 1'b1, CODE_HTTP1},
        '{{"HTTP/1.", 72'h0}, lead_mask(7), 5'd7, 1'b1, CODE_HTTP1},
        '{{"PRI * HTTP/2.0", 16'h0}, lead_mask(14), 5'd14, 1'b1, CODE_HTTP2},
        '{{"INVITE ", 72'h0}, lead_mask(7), 5'd7, 1'b1, CODE_SIP},
        '{{"REGISTER ", 56'h0}, lead_mask(9), 5'd9, 1'b1, CODE_SIP},
        '{{"ACK ", 96'h0}, lead_mask(4), 5'd4, 1'b1, CODE_SIP},
        '{{"BYE ", 96'h0}, lead_mask(4), 5'd4, 1'b1, CODE_SIP},
        '{{"SIP/2.0", 72'h0}, lead_mask(7), 5'd7, 1'b1, CODE_SIP},
        '{{"HELO ", 88'h0}, lead_mask(5), 5'd5, 1'b1, CODE_SMTP},
        '{{"EHLO ", 88'h0}, lead_mask(5), 5'd5, 1'b1, CODE_SMTP},
        '{{"MAIL FROM:", 48'h0}, lead_mask(10), 5'd10, 1'b1, CODE_SMTP},
        '{{"RCPT TO:", 64'h0}, lead_mask(8), 5'd8, 1'b1, CODE_SMTP},
        '{{"DATA", 96'h0}, lead_mask(4), 5'd4, 1'b1, CODE_SMTP},
        '{{"220 ", 96'h0}, lead_mask(4), 5'd4, 1'b1, CODE_SMTP},
        '{{"USER ", 88'h0}, lead_mask(5), 5'd5, 1'b1, CODE_FTP},
        '{{"PASS ", 88'h0}, lead_mask(5), 5'd5, 1'b1, CODE_FTP},
        '{{"220 ", 96'h0}, lead_mask(4), 5'd4, 1'b1, CODE_FTP},
        '{{"230 ", 96'h0}, lead_mask(4), 5'd4, 1'b1, CODE_FTP},
        '{{"530 ", 96'h0}, lead_mask(4), 5'd4, 1'b1, CODE_FTP}
    };

endpackage

### hdl/ppc_head_if.sv
// input channel carrying the payload head and length
interface ppc_head_if;
    logic        valid;
    logic        ready;
    logic [63:0] head_bytes_low;
    logic [63:0] head_bytes_high;
    logic [15:0] payload_length;

    modport source (output valid, head_bytes_low, head_bytes_high, payload_length,
                    input ready);
    modport sink (input valid, head_bytes_low, head_bytes_high, payload_length,
                  output ready);
endinterface

### hdl/ppc_verdict_if.sv
// output channel carrying the protocol verdict
interface ppc_verdict_if;
    logic       valid;
    logic       ready;
    logic [3:0] protocol_code;
    logic       by_signature;

    modport source (output valid, protocol_code, by_signature, input ready);
    modport sink (input valid, protocol_code, by_signature, output ready);
endinterface

### hdl/ppc_lane.sv
// one signature lane: masked compare of the head bytes plus length check
module ppc_lane (
    input  logic [ppc_pkg::HEAD_BITS-1:0] head_bytes,
    input  logic [ppc_pkg::LEN_W-1:0]     payload_length,
    input  ppc_pkg::pattern_t             pattern,
    output logic                          hit
);

    logic bytes_eq;
    logic len_ge;

    assign bytes_eq = (head_bytes & pattern.mask) == pattern.value;
    assign len_ge   = payload_length >= ppc_pkg::LEN_W'(pattern.min_len);
    assign hit      = bytes_eq && len_ge;

endmodule

### hdl/ppc_merge.sv
// merge of lane hits into one verdict in priority order
module ppc_merge (
    input  ppc_pkg::lane_hits_t hits,
    output ppc_pkg::result_t    result
);

    always_comb
    begin
        logic           found;
        ppc_pkg::code_t hint;
        found  = 1'b0;
        result = '{code: ppc_pkg::CODE_UNKNOWN, by_signature: 1'b0};
        for (int i = 0; i < ppc_pkg::NUM_PATS; i++)
        begin
            if (!found && ppc_pkg::PATTERNS[i].definite && hits.hit[i])
            begin
                found  = 1'b1;
                result = '{code: ppc_pkg::PATTERNS[i].code, by_signature: 1'b1};
            end
            if (i == ppc_pkg::DNS_AFTER && !found && hits.dns)
            begin
                found  = 1'b1;
                result = '{code: ppc_pkg::CODE_DNS, by_signature: 1'b1};
            end
        end
        // coap overrides quic, ntp only without an earlier hint
        if (hits.hit[ppc_pkg::IDX_COAP])
            hint = ppc_pkg::CODE_COAP;
        else if (hits.hit[ppc_pkg::IDX_QUIC])
            hint = ppc_pkg::CODE_QUIC;
        else if (hits.ntp)
            hint = ppc_pkg::CODE_NTP;
        else
            hint = ppc_pkg::CODE_UNKNOWN;
        if (!found)
            result = '{code: hint, by_signature: 1'b0};
        if (!hits.len_ok)
            result = '{code: ppc_pkg::CODE_UNKNOWN, by_signature: 1'b0};
    end

endmodule

### hdl/payload_protocol_classifier_unit.sv
// Payload protocol classifier: takes one word per cycle unless stalled (first sixteen
// payload bytes and the payload length) and returns one verdict word per input word,
// in order, through the hits register and then the result register. All 35 signature
// lanes plus the DNS count and NTP checks compare in the first stage; the second
// stage merges the lane hits by priority into the output register. A stalled
// output still lets one more word enter the first stage.
module payload_protocol_classifier_unit (
    input  logic          clk,
    input  logic          rst_n,
    ppc_head_if.sink      head,
    ppc_verdict_if.source verdict
);

    logic [ppc_pkg::HEAD_BITS-1:0] head_bytes;
    logic [ppc_pkg::NUM_PATS-1:0]  lane_hit;
    logic [15:0]                   dns_qd;
    logic [15:0]                   dns_an;
    ppc_pkg::lane_hits_t           hits_next;
    ppc_pkg::lane_hits_t           hits_reg;
    ppc_pkg::result_t              merged;
    ppc_pkg::result_t              result_reg;
    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic                          s1_adv;
    logic                          s2_adv;

    assign head_bytes = {head.head_bytes_low, head.head_bytes_high};

    for (genvar g = 0; g < ppc_pkg::NUM_PATS; g++)
    begin : g_lane
        ppc_lane u_lane (
            .head_bytes     (head_bytes),
            .payload_length (head.payload_length),
            .pattern        (ppc_pkg::PATTERNS[g]),
            .hit            (lane_hit[g])
        );
    end

    // dns question and answer counts, bytes 4..7
    assign dns_qd = head.head_bytes_low[31:16];
    assign dns_an = head.head_bytes_low[15:0];

    always_comb
    begin
        hits_next.hit    = lane_hit;
        hits_next.dns    = (head.payload_length >= ppc_pkg::LEN_W'(ppc_pkg::DNS_MIN_LEN))
                           && ((dns_qd != 16'd0) || (dns_an != 16'd0))
                           && (dns_qd < 16'(ppc_pkg::DNS_COUNT_LIMIT))
                           && (dns_an < 16'(ppc_pkg::DNS_COUNT_LIMIT));
        hits_next.ntp    = (head.payload_length >= ppc_pkg::LEN_W'(ppc_pkg::NTP_MIN_LEN))
                           && (head.head_bytes_low[58:56] != 3'd0);
        hits_next.len_ok = head.payload_length >= ppc_pkg::LEN_W'(ppc_pkg::MIN_PAYLOAD);
    end

    ppc_merge u_merge (
        .hits   (hits_reg),
        .result (merged)
    );

    assign s2_adv     = !out_valid_reg || verdict.ready;
    assign s1_adv     = !s1_valid_reg || s2_adv;
    assign head.ready = s1_adv;

    assign s1_valid_next  = s1_adv ? head.valid : s1_valid_reg;
    assign out_valid_next = s2_adv ? s1_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && head.valid)
            hits_reg <= hits_next;
        if (s2_adv && s1_valid_reg)
            result_reg <= merged;
    end

    assign verdict.valid         = out_valid_reg;
    assign verdict.protocol_code = 4'(result_reg.code);
    assign verdict.by_signature  = result_reg.by_signature;

endmodule

### hdl/ppc_checker.sv
// port-level checks of the classifier and their bind to the top level
module ppc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       head_valid,
    input logic       head_ready,
    input logic       verdict_valid,
    input logic       verdict_ready,
    input logic [3:0] protocol_code,
    input logic       by_signature
);

    logic head_acc;

    assign head_acc = head_valid && head_ready;

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        verdict_valid && !verdict_ready |=> verdict_valid && $stable(protocol_code)
            && $stable(by_signature))
        else $error("verdict changed while stalled");

    a_sig_definite: assert property (@(posedge clk) disable iff (!rst_n)
        verdict_valid && by_signature |-> protocol_code != ppc_pkg::CODE_UNKNOWN
            && protocol_code != ppc_pkg::CODE_QUIC && protocol_code != ppc_pkg::CODE_COAP
            && protocol_code != ppc_pkg::CODE_NTP && protocol_code <= ppc_pkg::CODE_FTP)
        else $error("definite verdict with hint or unknown code");

    a_hint_only: assert property (@(posedge clk) disable iff (!rst_n)
        verdict_valid && !by_signature |-> protocol_code == ppc_pkg::CODE_UNKNOWN
            || protocol_code == ppc_pkg::CODE_QUIC || protocol_code == ppc_pkg::CODE_COAP
            || protocol_code == ppc_pkg::CODE_NTP)
        else $error("non-definite verdict with signature code");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(verdict_valid) |-> $past(head_acc, 2))
        else $error("verdict without word accepted two cycles earlier");

endmodule

bind payload_protocol_classifier_unit ppc_checker u_ppc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_valid    (head.valid),
    .head_ready    (head.ready),
    .verdict_valid (verdict.valid),
    .verdict_ready (verdict.ready),
    .protocol_code (verdict.protocol_code),
    .by_signature  (verdict.by_signature)
);

### tb/sv/tb_payload_protocol_classifier_unit.sv
`timescale 1ns / 1ps
// self-checking testbench of the payload protocol classifier with random handshakes
module tb_payload_protocol_classifier_unit;

    localparam int RANDOM_ITEMS = 1040;
    localparam int PAUSE_ROUNDS = 5;
    localparam int PAUSE_BURST = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 8;
    localparam int REPORT_LIMIT = 10;
    localparam int NUM_WORDS = 34;

    logic clk = 1'b0;
    logic rst_n;

    ppc_head_if    head_bus ();
    ppc_verdict_if verdict_bus ();

    payload_protocol_classifier_unit DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head_bus),
        .verdict (verdict_bus)
    );

    ppc_pkg::result_t pending_verdicts [$];
    int               mismatch_count = 0;
    int               quiet_cycles = 0;
    int               stall_left = 0;
    bit               idle_on = 1'b1;

    string protocol_words [NUM_WORDS] = '{
        "SSH-", "RTSP/", "OPTIONS ", "DESCRIBE ", "SETUP ", "PLAY ",
        "GET ", "POST ", "PUT ", "DELETE ", "HEAD ", "PATCH ", "HTTP/1.",
        "PRI * HTTP/2.0", "INVITE ", "REGISTER ", "ACK ", "BYE ", "SIP/2.0",
        "HELO ", "EHLO ", "MAIL FROM:", "RCPT TO:", "DATA", "220 ",
        "USER ", "PASS ", "230 ", "530 ", "HTTP/1.1 ", "SIP/2.0 ",
        "GET /", "RTSP/1.0", "220 ftp"
    };

    always #5 clk = ~clk;

    function automatic bit has_lead(input logic [127:0] head, input int unsigned len,
                                    input string word);
        bit hit;
        hit = (len >= word.len());
        for (int i = 0; i < word.len(); i++)
            if (head[127-8*i -: 8] != word[i])
                hit = 1'b0;
        return hit;
    endfunction

    function automatic logic [127:0] put_lead(input logic [127:0] head, input string word);
        logic [127:0] result;
        result = head;
        for (int i = 0; i < word.len(); i++)
            result[127-8*i -: 8] = word[i];
        return result;
    endfunction

    function automatic ppc_pkg::result_t classify_payload(input logic [127:0] head,
                                                          input logic [15:0] length);
        ppc_pkg::result_t verdict;
        ppc_pkg::code_t   hint;
        logic [7:0]       lead;
        logic [15:0]      qd_count;
        logic [15:0]      an_count;
        int unsigned      len;
        len = length;
        lead = head[127:120];
        qd_count = head[95:80];
        an_count = head[79:64];
        hint = ppc_pkg::CODE_UNKNOWN;
        verdict.code = ppc_pkg::CODE_UNKNOWN;
        verdict.by_signature = 1'b1;
        if (len < ppc_pkg::MIN_PAYLOAD)
            verdict.by_signature = 1'b0;
        else if (len >= 5 && lead == 8'h16 && head[119:112] == 8'h03)
            verdict.code = ppc_pkg::CODE_TLS;
        else if (has_lead(head, len, "SSH-"))
            verdict.code = ppc_pkg::CODE_SSH;
        else if (lead[7:4] == 4'h1)
            verdict.code = ppc_pkg::CODE_MQTT;
        else if (has_lead(head, len, "RTSP/") || has_lead(head, len, "OPTIONS ")
                 || has_lead(head, len, "DESCRIBE ") || has_lead(head, len, "SETUP ")
                 || has_lead(head, len, "PLAY "))
            verdict.code = ppc_pkg::CODE_RTSP;
        else
        begin
            if (len >= 6 && lead[7])
                hint = ppc_pkg::CODE_QUIC;
            if (len >= 4 && lead[7:6] == 2'b01)
                hint = ppc_pkg::CODE_COAP;
            if (len >= ppc_pkg::DNS_MIN_LEN && (qd_count != 16'd0 || an_count != 16'd0)
                && qd_count < 16'(ppc_pkg::DNS_COUNT_LIMIT)
                && an_count < 16'(ppc_pkg::DNS_COUNT_LIMIT))
                verdict.code = ppc_pkg::CODE_DNS;
            else if (has_lead(head, len, "GET ") || has_lead(head, len, "POST ")
                     || has_lead(head, len, "PUT ") || has_lead(head, len, "DELETE ")
                     || has_lead(head, len, "HEAD ") || has_lead(head, len, "OPTIONS ")
                     || has_lead(head, len, "PATCH ") || has_lead(head, len, "HTTP/1."))
                verdict.code = ppc_pkg::CODE_HTTP1;
            else if (has_lead(head, len, "PRI * HTTP/2.0"))
                verdict.code = ppc_pkg::CODE_HTTP2;
            else if (has_lead(head, len, "INVITE ") || has_lead(head, len, "REGISTER ")
                     || has_lead(head, len, "ACK ") || has_lead(head, len, "BYE ")
                     || has_lead(head, len, "SIP/2.0"))
                verdict.code = ppc_pkg::CODE_SIP;
            else if (has_lead(head, len, "HELO ") || has_lead(head, len, "EHLO ")
                     || has_lead(head, len, "MAIL FROM:") || has_lead(head, len, "RCPT TO:")
                     || has_lead(head, len, "DATA") || has_lead(head, len, "220 "))
                verdict.code = ppc_pkg::CODE_SMTP;
            else
            begin
                if (len >= ppc_pkg::NTP_MIN_LEN && lead[2:0] != 3'b0
                    && hint == ppc_pkg::CODE_UNKNOWN)
                    hint = ppc_pkg::CODE_NTP;
                if (has_lead(head, len, "USER ") || has_lead(head, len, "PASS ")
                    || has_lead(head, len, "220 ") || has_lead(head, len, "230 ")
                    || has_lead(head, len, "530 "))
                    verdict.code = ppc_pkg::CODE_FTP;
                else
                begin
                    verdict.code = hint;
                    verdict.by_signature = 1'b0;
                end
            end
        end
        return verdict;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // word stays valid after acceptance until the next call or park_source
    task automatic send_word(input logic [127:0] head, input logic [15:0] length);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            head_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        head_bus.valid <= 1'b1;
        head_bus.head_bytes_low <= head[127:64];
        head_bus.head_bytes_high <= head[63:0];
        head_bus.payload_length <= length;
        do @(posedge clk); while (!head_bus.ready);
        pending_verdicts.push_back(classify_payload(head, length));
    endtask

    task automatic park_source();
        head_bus.valid <= 1'b0;
    endtask

    task automatic wait_all_verdicts();
        do @(posedge clk); while (pending_verdicts.size() != 0);
    endtask

    task automatic random_item(output logic [127:0] head, output logic [15:0] length);
        int    kind;
        int    n;
        int    r;
        int    pos;
        string word;
        head = {$urandom, $urandom, $urandom, $urandom};
        n = 16;
        kind = $urandom_range(0, 9);
        if (kind <= 3)
        begin
            word = protocol_words[$urandom_range(0, NUM_WORDS - 1)];
            head = put_lead(head, word);
            n = word.len();
            // broken prefix
            if (kind == 3)
            begin
                pos = $urandom_range(0, n - 1);
                head[127-8*pos -: 8] ^= 8'(1 << $urandom_range(0, 7));
            end
        end
        else if (kind == 4)
        begin
            head[127:112] = 16'h1603;
            n = 5;
        end
        else if (kind == 5)
        begin
            head[95:80] = 16'($urandom_range(0, 70));
            head[79:64] = 16'($urandom_range(0, 70));
            n = ppc_pkg::DNS_MIN_LEN;
        end
        else if (kind == 6)
        begin
            head[95:64] = 32'h0;
            n = $urandom_range(4, 8);
        end
        r = $urandom_range(0, 9);
        if (r < 5)
            length = 16'(n + $urandom_range(0, 2) - 1);
        else if (r < 8)
            length = 16'($urandom_range(0, 20));
        else
            length = 16'($urandom_range(0, 65535));
    endtask

    task automatic test_length_extremes();
        send_word('1, 16'd0);
        send_word(put_lead('0, "SSH-"), 16'd1);
        send_word('0, 16'hFFFF);
        send_word('1, 16'hFFFF);
    endtask

    task automatic test_definite_rules();
        logic [127:0] head;
        send_word({16'h1603, 112'h0}, 16'd5);
        send_word({16'h1603, 112'h0}, 16'd4);
        send_word(put_lead('0, "SSH-"), 16'd4);
        send_word({8'h1F, 8'hAA, 112'h0}, 16'd2);
        send_word(put_lead('0, "RTSP/"), 16'd5);
        send_word(put_lead('0, "GET "), 16'd4);
        send_word(put_lead('0, "GET "), 16'd3);
        send_word(put_lead('0, "PRI * HTTP/2.0"), 16'd14);
        send_word(put_lead('0, "INVITE "), 16'd7);
        send_word(put_lead('0, "MAIL FROM:"), 16'd10);
        send_word(put_lead('0, "USER "), 16'd5);
        send_word(put_lead('0, "230 "), 16'd4);
        head = '0;
        head[95:80] = 16'd1;
        send_word(head, 16'(ppc_pkg::DNS_MIN_LEN));
        head[95:80] = 16'(ppc_pkg::DNS_COUNT_LIMIT);
        send_word(head, 16'(ppc_pkg::DNS_MIN_LEN));
    endtask

    task automatic test_hint_rules();
        send_word({8'hC0, 120'h0}, 16'd6);
        send_word({8'h40, 120'h0}, 16'd4);
        send_word({8'h23, 120'h0}, 16'(ppc_pkg::NTP_MIN_LEN));
        send_word({8'h83, 120'h0}, 16'(ppc_pkg::NTP_MIN_LEN));
    endtask

    task automatic test_shared_prefixes();
        logic [127:0] head;
        send_word(put_lead('0, "OPTIONS "), 16'd8);
        send_word(put_lead('0, "220 "), 16'd4);
        head = '1;
        head[127:120] = 8'h45;
        head[95:64] = {16'd3, 16'd2};
        send_word(head, 16'd40);
    endtask

    task automatic test_drain_pauses();
        logic [127:0] head;
        logic [15:0]  length;
        for (int round = 0; round < PAUSE_ROUNDS; round++)
        begin
            for (int i = 0; i < PAUSE_BURST; i++)
            begin
                random_item(head, length);
                send_word(head, length);
            end
            park_source();
            wait_all_verdicts();
        end
    endtask

    task automatic test_random_traffic();
        logic [127:0] head;
        logic [15:0]  length;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 150 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            random_item(head, length);
            send_word(head, length);
        end
        idle_on = 1'b1;
    endtask

    // sink side with random stalls
    initial
    begin
        verdict_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                verdict_bus.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                verdict_bus.ready <= 1'b1;
                if (idle_on && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin : verdict_check
        ppc_pkg::result_t expected;
        if (rst_n && verdict_bus.valid && verdict_bus.ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected verdict: code %0d sig %0b",
                             verdict_bus.protocol_code, verdict_bus.by_signature);
            end
            else
            begin
                expected = pending_verdicts.pop_front();
                if (verdict_bus.protocol_code !== expected.code
                    || verdict_bus.by_signature !== expected.by_signature)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display({"verdict mismatch: expected code %0d sig %0b, ",
                                  "got code %0d sig %0b"},
                                 expected.code, expected.by_signature,
                                 verdict_bus.protocol_code, verdict_bus.by_signature);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((head_bus.valid && head_bus.ready) || (verdict_bus.valid && verdict_bus.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        head_bus.valid <= 1'b0;
        head_bus.head_bytes_low <= '0;
        head_bus.head_bytes_high <= '0;
        head_bus.payload_length <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_length_extremes();
        test_definite_rules();
        test_hint_rules();
        test_shared_prefixes();
        test_drain_pauses();
        test_random_traffic();
        park_source();
        wait_all_verdicts();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
